// ===== hw/rtl/binary_heap_priority_queue_assert.svh =====
`ifndef BINARY_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle check, clocked on clk, off while rst is high.
`define BHPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle check, clocked on clk, off while rst is high.
`define BHPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bhpq_pkg.sv =====
package bhpq_pkg;

  localparam int DEPTH_DEF         = 64;
  localparam int KEY_WIDTH_DEF     = 32;
  localparam int PAYLOAD_WIDTH_DEF = 32;

  // request codes
  localparam logic [1:0] MODE_INSERT  = 2'd0;
  localparam logic [1:0] MODE_EXTRACT = 2'd1;
  localparam logic [1:0] MODE_PEEK    = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] key;
    logic [31:0] payload;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] top_key;
    logic [31:0] top_payload;
    logic [6:0]  count;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_TOP_RD,
    S_TOP_GET,
    S_LAST_GET,
    S_DN_L,
    S_DN_R,
    S_DN_PICK,
    S_DN_CMP,
    S_WR,
    S_DONE
  } state_t;

endpackage

// ===== hw/rtl/bhpq_ram.sv =====
module bhpq_ram #(
  parameter int WIDTH = bhpq_pkg::KEY_WIDTH_DEF + bhpq_pkg::PAYLOAD_WIDTH_DEF,
  parameter int DEPTH = bhpq_pkg::DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/bhpq_cmp.sv =====
module bhpq_cmp #(
  parameter int KEY_WIDTH = bhpq_pkg::KEY_WIDTH_DEF
) (
  input  logic                 order,
  input  logic [KEY_WIDTH-1:0] a_key,
  input  logic [KEY_WIDTH-1:0] b_key,
  output logic                 worse
);

  // a ranks below b: smaller when largest-first, larger when smallest-first
  assign worse = order ? (a_key > b_key) : (a_key < b_key);

endmodule

// ===== hw/rtl/binary_heap_priority_queue.sv =====
// Binary heap priority queue: one request per start/busy beat, one result per done strobe.
// Insert reads each parent and compares it with the new entry, moving worse parents down;
// extract reads the top and, unless it was the only entry, the last entry, then sifts down
// through the children; peek reads the top; empty/full/unused go straight to done. One RAM, one comparator.
// Busy clears the cycle after done; results never stall.
// Synchronous reset empties the heap and selects largest-first order.
`include "binary_heap_priority_queue_assert.svh"

module binary_heap_priority_queue #(
  parameter int DEPTH         = bhpq_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH     = bhpq_pkg::KEY_WIDTH_DEF,
  parameter int PAYLOAD_WIDTH = bhpq_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  bhpq_pkg::cmd_t    cmd,
  output logic              done,
  output bhpq_pkg::result_t result,
  input  logic              cfg_we,
  input  logic              cfg_data
);

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int EW  = KEY_WIDTH + PAYLOAD_WIDTH;
  localparam int CHW = AW + 2;

  bhpq_pkg::state_t state, state_next;

  // control state
  logic          order;
  logic [CW-1:0] count;
  logic          op_extract;

  // working registers
  logic [AW-1:0]            pos;
  logic [AW-1:0]            bidx;
  logic [EW-1:0]            item;
  logic [EW-1:0]            best;
  logic [1:0]               rstat;
  logic [KEY_WIDTH-1:0]     rkey;
  logic [PAYLOAD_WIDTH-1:0] rpay;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  // shared comparator
  logic [KEY_WIDTH-1:0] cmp_a;
  logic [KEY_WIDTH-1:0] cmp_b;
  logic                 worse;

  // index math
  logic [AW-1:0]  parent;
  logic [CHW-1:0] child_w;
  logic [CHW-1:0] right_w;
  logic [CHW-1:0] count_w;
  logic           full;
  logic           empty;
  logic           is_ins;
  logic           is_top;

  assign parent  = (pos - AW'(1)) >> 1;
  assign child_w = {1'b0, pos, 1'b1};
  assign right_w = child_w + CHW'(1);
  assign count_w = CHW'(count);
  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign is_ins  = (cmd.mode == bhpq_pkg::MODE_INSERT);
  assign is_top  = (cmd.mode == bhpq_pkg::MODE_EXTRACT) || (cmd.mode == bhpq_pkg::MODE_PEEK);

  bhpq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bhpq_cmp #(
    .KEY_WIDTH (KEY_WIDTH)
  ) u_cmp (
    .order (order),
    .a_key (cmp_a),
    .b_key (cmp_b),
    .worse (worse)
  );

  // Comparator operand select: parent vs item going up, left vs right when
  // picking a child, item vs chosen child going down.
  always_comb begin
    cmp_a = item[EW-1:PAYLOAD_WIDTH];
    cmp_b = best[EW-1:PAYLOAD_WIDTH];
    if (state == bhpq_pkg::S_UP_CMP) begin
      cmp_a = ram_rdata[EW-1:PAYLOAD_WIDTH];
      cmp_b = item[EW-1:PAYLOAD_WIDTH];
    end else if (state == bhpq_pkg::S_DN_PICK) begin
      cmp_a = best[EW-1:PAYLOAD_WIDTH];
      cmp_b = ram_rdata[EW-1:PAYLOAD_WIDTH];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bhpq_pkg::S_IDLE: begin
        if (start) begin
          if (is_ins) begin
            state_next = full ? bhpq_pkg::S_DONE : bhpq_pkg::S_UP_RD;
          end else if (is_top) begin
            state_next = empty ? bhpq_pkg::S_DONE : bhpq_pkg::S_TOP_RD;
          end else begin
            state_next = bhpq_pkg::S_DONE;
          end
        end
      end
      bhpq_pkg::S_UP_RD: begin
        state_next = (pos == '0) ? bhpq_pkg::S_WR : bhpq_pkg::S_UP_CMP;
      end
      bhpq_pkg::S_UP_CMP: begin
        state_next = worse ? bhpq_pkg::S_UP_RD : bhpq_pkg::S_WR;
      end
      bhpq_pkg::S_TOP_RD: begin
        state_next = bhpq_pkg::S_TOP_GET;
      end
      bhpq_pkg::S_TOP_GET: begin
        if (!op_extract || count == CW'(1)) begin
          state_next = bhpq_pkg::S_DONE;
        end else begin
          state_next = bhpq_pkg::S_LAST_GET;
        end
      end
      bhpq_pkg::S_LAST_GET: begin
        state_next = bhpq_pkg::S_DN_L;
      end
      bhpq_pkg::S_DN_L: begin
        state_next = (child_w >= count_w) ? bhpq_pkg::S_WR : bhpq_pkg::S_DN_R;
      end
      bhpq_pkg::S_DN_R: begin
        state_next = (right_w < count_w) ? bhpq_pkg::S_DN_PICK : bhpq_pkg::S_DN_CMP;
      end
      bhpq_pkg::S_DN_PICK: begin
        state_next = bhpq_pkg::S_DN_CMP;
      end
      bhpq_pkg::S_DN_CMP: begin
        state_next = worse ? bhpq_pkg::S_DN_L : bhpq_pkg::S_WR;
      end
      bhpq_pkg::S_WR: begin
        state_next = bhpq_pkg::S_DONE;
      end
      bhpq_pkg::S_DONE: begin
        state_next = bhpq_pkg::S_IDLE;
      end
      default: begin
        state_next = bhpq_pkg::S_IDLE;
      end
    endcase
  end

  // outputs and RAM control
  always_comb begin
    busy      = (state != bhpq_pkg::S_IDLE);
    done      = (state == bhpq_pkg::S_DONE);
    ram_we    = 1'b0;
    ram_waddr = pos;
    ram_wdata = item;
    ram_raddr = '0;
    unique case (state)
      bhpq_pkg::S_UP_RD: begin
        ram_raddr = parent;
      end
      bhpq_pkg::S_UP_CMP: begin
        // parent moves down into the hole
        ram_we    = worse;
        ram_wdata = ram_rdata;
      end
      bhpq_pkg::S_TOP_GET: begin
        ram_raddr = AW'(count - CW'(1));
      end
      bhpq_pkg::S_DN_L: begin
        ram_raddr = child_w[AW-1:0];
      end
      bhpq_pkg::S_DN_R: begin
        ram_raddr = right_w[AW-1:0];
      end
      bhpq_pkg::S_DN_CMP: begin
        // better child moves up into the hole
        ram_we    = worse;
        ram_wdata = best;
      end
      bhpq_pkg::S_WR: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    result.status      = rstat;
    result.top_key     = 32'(rkey);
    result.top_payload = 32'(rpay);
    result.count       = 7'(count);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bhpq_pkg::S_IDLE;
      order <= 1'b0;
      count <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        order <= cfg_data;
      end
      if (state == bhpq_pkg::S_IDLE && start && is_ins && !full) begin
        count <= count + CW'(1);
      end
      if (state == bhpq_pkg::S_TOP_GET && op_extract) begin
        count <= count - CW'(1);
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      bhpq_pkg::S_IDLE: begin
        if (start) begin
          op_extract <= (cmd.mode == bhpq_pkg::MODE_EXTRACT);
          rkey       <= '0;
          rpay       <= '0;
          rstat      <= bhpq_pkg::STAT_OK;
          item       <= {cmd.key[KEY_WIDTH-1:0], cmd.payload[PAYLOAD_WIDTH-1:0]};
          pos        <= AW'(count);
          if (is_ins && full) begin
            rstat <= bhpq_pkg::STAT_FULL;
          end else if (is_top && empty) begin
            rstat <= bhpq_pkg::STAT_EMPTY;
          end
        end
      end
      bhpq_pkg::S_UP_CMP: begin
        if (worse) begin
          pos <= parent;
        end
      end
      bhpq_pkg::S_TOP_GET: begin
        rkey <= ram_rdata[EW-1:PAYLOAD_WIDTH];
        rpay <= ram_rdata[PAYLOAD_WIDTH-1:0];
      end
      bhpq_pkg::S_LAST_GET: begin
        item <= ram_rdata;
        pos  <= '0;
      end
      bhpq_pkg::S_DN_R: begin
        best <= ram_rdata;
        bidx <= child_w[AW-1:0];
      end
      bhpq_pkg::S_DN_PICK: begin
        // right child wins only when left is strictly worse
        if (worse) begin
          best <= ram_rdata;
          bidx <= right_w[AW-1:0];
        end
      end
      bhpq_pkg::S_DN_CMP: begin
        if (worse) begin
          pos <= bidx;
        end
      end
      default: begin
      end
    endcase
  end

  `BHPQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
  `BHPQ_ASSERT_NEXT(a_done_single, done, !done, "done held longer than one cycle")
  `BHPQ_ASSERT_NOW(a_count_range, 1'b1, count <= CW'(DEPTH), "entry count above depth")
  `BHPQ_ASSERT_NOW(a_wr_in_heap, ram_we, (CW+1)'(ram_waddr) < (CW+1)'(count), "heap write past last entry")

endmodule
